### src/assert_macros.svh
// Assertion macros shared by the slot scheduler RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/sst_pkg.sv
// Shared types and constants for the slot scheduler with sleep timers.
// Used by the controller, the datapath and the top level; depends on nothing.
package sst_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int MAX_RESULTS = 16;
  localparam int RUN_W       = $clog2(MAX_RESULTS + 1);
  localparam int WAIT_W      = 18;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SLEEP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_READY = 2'd1,
    ST_SLEEP = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    RES_RUN     = 3'd0,
    RES_CREATED = 3'd1,
    RES_DELETED = 3'd2,
    RES_ASLEEP  = 3'd3,
    RES_NONE    = 3'd4,
    RES_FULL    = 3'd5,
    RES_BAD     = 3'd6
  } res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANTUM = 1'b0,
    CFG_TPU     = 1'b1
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick;
    logic create;
    logic remove;
    logic sleep;
    logic pass_step;
    logic find_step;
    logic flush;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic expire;
    logic idx_last;
    logic find_hit;
  } sts_t;

endpackage

### src/slot_scheduler_with_sleep_timers_unit.sv
// Top level of the slot scheduler with sleep timers.
// Depends on sst_pkg, assert_macros.svh, sst_ctrl and sst_datapath.

// A request is taken when start is high and busy is low. Delete and sleep do not
// raise busy and answer in the next cycle. A tick that does not end the quantum
// answers in the next cycle; one that ends it runs a scheduling pass that walks the
// slot table one slot per cycle, so busy stays high through the pass and the flush
// state after it. The run results of a pass come out in ascending slot order, each
// in the cycle after the next ready slot is reached, the last one flagged. Create
// also walks the table one slot per cycle up to the lowest free slot or its end.
// Every result is shown for exactly one cycle with valid high and cannot be held off.
// Configuration writes take effect at once and belong only to idle periods.
`include "assert_macros.svh"

module slot_scheduler_with_sleep_timers_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic [1:0]                    command,
  input  logic [3:0]                    slot_index,
  input  logic [31:0]                   task_handle,
  input  logic [9:0]                    sleep_units,
  output logic                          valid,
  output logic [2:0]                    status,
  output logic [3:0]                    slot,
  output logic [31:0]                   handle,
  output logic                          last
);
  import sst_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic single_req;

  sst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy)
  );

  sst_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .slot_index  (slot_index),
    .task_handle (task_handle),
    .sleep_units (sleep_units),
    .valid       (valid),
    .status      (status),
    .slot        (slot),
    .handle      (handle),
    .last        (last)
  );

  assign single_req = start && !busy && (command == CMD_REMOVE || command == CMD_SLEEP);

  `ASSERT_NEXT(a_idle_quiet, !busy && !start, !valid, "result without a request")
  `ASSERT_NEXT(a_single_answer, single_req, valid && last, "delete or sleep not answered")
  `ASSERT_ALWAYS(a_only_run_continues, !valid || status == RES_RUN || last, "lone result not last")

endmodule

### src/sst_ctrl.sv
// Controller state machine of the slot scheduler.
// Depends on sst_pkg; drives the datapath through ctl_t and reads sts_t.
module sst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    command,
  input  sst_pkg::sts_t sts,
  output sst_pkg::ctl_t ctl,
  output logic          busy
);
  import sst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PASS  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_FIND  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_t'(command))
            CMD_TICK: begin
              ctl.tick = 1'b1;
              if (sts.expire) begin
                state_next = S_PASS;
              end
            end
            CMD_CREATE: begin
              ctl.create = 1'b1;
              state_next = S_FIND;
            end
            CMD_REMOVE: begin
              ctl.remove = 1'b1;
            end
            CMD_SLEEP: begin
              ctl.sleep = 1'b1;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_PASS: begin
        ctl.pass_step = 1'b1;
        if (sts.idx_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        ctl.flush  = 1'b1;
        state_next = S_IDLE;
      end
      S_FIND: begin
        ctl.find_step = 1'b1;
        if (sts.find_hit || sts.idx_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### src/sst_datapath.sv
// Datapath of the slot scheduler: slot table, timers, quantum counter and result register.
// Depends on sst_pkg; takes its commands from sst_ctrl.
module sst_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  sst_pkg::ctl_t              ctl,
  output sst_pkg::sts_t              sts,
  input  logic                       cfg_we,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                 cfg_data,
  input  logic [3:0]                 slot_index,
  input  logic [31:0]                task_handle,
  input  logic [9:0]                 sleep_units,
  output logic                       valid,
  output logic [2:0]                 status,
  output logic [3:0]                 slot,
  output logic [31:0]                handle,
  output logic                       last
);
  import sst_pkg::*;

  logic [7:0]        quantum;
  logic [7:0]        ticks_per_unit;
  logic [7:0]        quantum_left;
  logic [SLOT_W-1:0] current_slot;
  slot_st_t          slot_st [SLOTS];
  logic [31:0]       slot_handle [SLOTS];
  logic [WAIT_W-1:0] slot_wait [SLOTS];

  logic [SLOT_W-1:0] idx;
  logic [RUN_W-1:0]  n_run;
  logic [31:0]       hnd;
  logic              pend_valid;
  logic [SLOT_W-1:0] pend_slot;
  logic [31:0]       pend_handle;

  logic              emit;
  res_t              e_status;
  logic [SLOT_W-1:0] e_slot;
  logic [31:0]       e_handle;
  logic              e_last;

  logic              run_take;
  logic [WAIT_W-1:0] wait_dec;
  logic [WAIT_W-1:0] prod;
  logic [WAIT_W-1:0] wait_new;
  logic              remove_bad;
  logic              sleep_bad;

  assign sts.expire   = (quantum_left == 8'd1);
  assign sts.idx_last = (idx == SLOT_W'(SLOTS - 1));
  assign sts.find_hit = (slot_st[idx] == ST_FREE);

  assign run_take   = (slot_st[idx] == ST_READY) && (n_run < RUN_W'(MAX_RESULTS));
  assign wait_dec   = slot_wait[idx] - WAIT_W'(1);
  assign prod       = WAIT_W'(sleep_units) * WAIT_W'(ticks_per_unit);
  assign wait_new   = (prod == '0) ? WAIT_W'(1) : prod;
  assign remove_bad = (slot_st[slot_index] == ST_FREE);
  assign sleep_bad  = (slot_st[current_slot] == ST_FREE);

  always_comb begin
    emit     = 1'b0;
    e_status = RES_NONE;
    e_slot   = '0;
    e_handle = '0;
    e_last   = 1'b1;
    if (ctl.tick && !sts.expire) begin
      emit = 1'b1;
    end
    if (ctl.find_step) begin
      if (sts.find_hit) begin
        emit     = 1'b1;
        e_status = RES_CREATED;
        e_slot   = idx;
      end else if (sts.idx_last) begin
        emit     = 1'b1;
        e_status = RES_FULL;
      end
    end
    if (ctl.remove) begin
      emit     = 1'b1;
      e_status = remove_bad ? RES_BAD : RES_DELETED;
      e_slot   = slot_index;
    end
    if (ctl.sleep) begin
      emit     = 1'b1;
      e_status = sleep_bad ? RES_BAD : RES_ASLEEP;
      e_slot   = current_slot;
    end
    // A ready slot releases the one held back, which is then known not to be the last.
    if (ctl.pass_step && run_take && pend_valid) begin
      emit     = 1'b1;
      e_status = RES_RUN;
      e_slot   = pend_slot;
      e_handle = pend_handle;
      e_last   = 1'b0;
    end
    if (ctl.flush) begin
      emit = 1'b1;
      if (pend_valid) begin
        e_status = RES_RUN;
        e_slot   = pend_slot;
        e_handle = pend_handle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      quantum        <= 8'd1;
      ticks_per_unit <= 8'd60;
      quantum_left   <= 8'd1;
      current_slot   <= '0;
      pend_valid     <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_st[i] <= ST_FREE;
      end
    end else begin
      valid <= emit;
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_index) == CFG_QUANTUM) begin
          quantum <= cfg_data;
        end else begin
          ticks_per_unit <= cfg_data;
        end
      end
      if (ctl.tick) begin
        quantum_left <= sts.expire ? quantum : quantum_left - 8'd1;
        pend_valid   <= 1'b0;
      end
      if (ctl.find_step && sts.find_hit) begin
        slot_st[idx] <= ST_READY;
      end
      if (ctl.remove && !remove_bad) begin
        slot_st[slot_index] <= ST_FREE;
      end
      if (ctl.sleep && !sleep_bad) begin
        slot_st[current_slot] <= ST_SLEEP;
      end
      if (ctl.pass_step) begin
        if (slot_st[idx] == ST_READY) begin
          current_slot <= idx;
          if (run_take) begin
            pend_valid <= 1'b1;
          end
        end else if (slot_st[idx] == ST_SLEEP && wait_dec == '0) begin
          slot_st[idx] <= ST_READY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    status <= 3'(e_status);
    slot   <= 4'(e_slot);
    handle <= e_handle;
    last   <= e_last;
    if (ctl.tick || ctl.create) begin
      idx   <= '0;
      n_run <= '0;
    end else if (ctl.pass_step || ctl.find_step) begin
      idx <= idx + SLOT_W'(1);
    end
    if (ctl.create) begin
      hnd <= task_handle;
    end
    if (ctl.find_step && sts.find_hit) begin
      slot_handle[idx] <= hnd;
    end
    if (ctl.sleep && !sleep_bad) begin
      slot_wait[current_slot] <= wait_new;
    end
    if (ctl.pass_step) begin
      if (run_take) begin
        pend_slot   <= idx;
        pend_handle <= slot_handle[idx];
        n_run       <= n_run + RUN_W'(1);
      end else if (slot_st[idx] == ST_SLEEP) begin
        slot_wait[idx] <= wait_dec;
      end
    end
  end

endmodule
